[rtl/core/vang_pkg.sv]
// Shared constants and the arctangent table for the vector angle block.
package vang_pkg;

	localparam int ANGLE_WIDTH = 16;
	localparam int Z_WIDTH     = 35;
	localparam int ATAN_DEPTH  = 32;

	localparam logic signed [Z_WIDTH-1:0] PI_2_Q32 = 35'sd6746518852;
	localparam logic signed [Z_WIDTH-1:0] PI_Q32   = 35'sd13493037704;

	localparam logic [31:0] ATAN_Q32 [0:ATAN_DEPTH-1] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
		32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
		32'd1048576,    32'd524288,     32'd262144,     32'd131072,
		32'd65536,      32'd32768,      32'd16384,      32'd8192,
		32'd4096,       32'd2048,       32'd1024,       32'd512,
		32'd256,        32'd128,        32'd64,         32'd32,
		32'd16,         32'd8,          32'd4,          32'd2
	};

endpackage

[rtl/core/vang_if.sv]
// Channel interfaces: vector pair in, angle result out.
interface vang_pair_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;

	modport source (output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface vang_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] angle;
	logic        zero_vector;

	modport source (output valid, angle, zero_vector, input ready);
	modport sink   (input valid, angle, zero_vector, output ready);
endinterface

[rtl/core/vang_prep.sv]
// Front end: products, dot and cross, and the quadrant pre-rotation.
module vang_prep #(
	parameter int COORD_WIDTH = 16,
	parameter int DW          = 35
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_up,
	output logic                            ready_up,
	input  logic signed [COORD_WIDTH-1:0]   x1,
	input  logic signed [COORD_WIDTH-1:0]   y1,
	input  logic signed [COORD_WIDTH-1:0]   x2,
	input  logic signed [COORD_WIDTH-1:0]   y2,
	output logic                            valid_dn,
	input  logic                            ready_dn,
	output logic signed [DW-1:0]            x_dn,
	output logic signed [DW-1:0]            y_dn,
	output logic signed [vang_pkg::Z_WIDTH-1:0] z_dn,
	output logic                            zero_dn
);
	import vang_pkg::*;

	localparam int PW  = 2 * COORD_WIDTH;
	localparam int PRE = (PW > 60) ? PW - 60 : 0;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 ready_s1, ready_s2, ready_s3;
	logic signed [PW-1:0] p_xx_s1, p_yy_s1, p_xy_s1, p_yx_s1;
	logic                 zero_s1, zero_s2, zero_s3;
	logic signed [DW-1:0] dot_s2, cross_s2;
	logic signed [DW-1:0] x_s3, y_s3;
	logic signed [Z_WIDTH-1:0] z_s3;
	logic signed [DW-1:0] s_xx, s_yy, s_xy, s_yx;
	logic signed [DW-1:0] abs_cross;

	assign ready_s3 = !valid_s3 || ready_dn;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign ready_up = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= valid_up;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_up && ready_s1) begin
			p_xx_s1 <= PW'(x1) * PW'(x2);
			p_yy_s1 <= PW'(y1) * PW'(y2);
			p_xy_s1 <= PW'(x1) * PW'(y2);
			p_yx_s1 <= PW'(y1) * PW'(x2);
			zero_s1 <= ((x1 == '0) && (y1 == '0)) || ((x2 == '0) && (y2 == '0));
		end
	end

	assign s_xx = DW'(p_xx_s1 >>> PRE);
	assign s_yy = DW'(p_yy_s1 >>> PRE);
	assign s_xy = DW'(p_xy_s1 >>> PRE);
	assign s_yx = DW'(p_yx_s1 >>> PRE);

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			dot_s2   <= s_xx + s_yy;
			cross_s2 <= s_xy - s_yx;
			zero_s2  <= zero_s1;
		end
	end

	assign abs_cross = cross_s2[DW-1] ? -cross_s2 : cross_s2;

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			zero_s3 <= zero_s2;
			if (dot_s2[DW-1]) begin
				x_s3 <= abs_cross;
				y_s3 <= -dot_s2;
				z_s3 <= PI_2_Q32;
			end else begin
				x_s3 <= dot_s2;
				y_s3 <= abs_cross;
				z_s3 <= '0;
			end
		end
	end

	assign valid_dn = valid_s3;
	assign x_dn     = x_s3;
	assign y_dn     = y_s3;
	assign z_dn     = z_s3;
	assign zero_dn  = zero_s3;

endmodule

[rtl/core/vang_cell.sv]
// One vectoring CORDIC iteration with its own pipeline register.
module vang_cell #(
	parameter int DW   = 35,
	parameter int STEP = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_up,
	output logic                                ready_up,
	input  logic signed [DW-1:0]                x_up,
	input  logic signed [DW-1:0]                y_up,
	input  logic signed [vang_pkg::Z_WIDTH-1:0] z_up,
	input  logic                                zero_up,
	output logic                                valid_dn,
	input  logic                                ready_dn,
	output logic signed [DW-1:0]                x_dn,
	output logic signed [DW-1:0]                y_dn,
	output logic signed [vang_pkg::Z_WIDTH-1:0] z_dn,
	output logic                                zero_dn
);
	import vang_pkg::*;

	localparam logic signed [Z_WIDTH-1:0] ATAN_STEP = Z_WIDTH'(ATAN_Q32[STEP]);

	logic                      valid_q;
	logic signed [DW-1:0]      x_q, y_q;
	logic signed [Z_WIDTH-1:0] z_q;
	logic                      zero_q;
	logic signed [DW-1:0]      dx, dy;

	assign ready_up = !valid_q || ready_dn;
	assign dx = y_up >>> STEP;
	assign dy = x_up >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_up && ready_up) begin
			zero_q <= zero_up;
			if (!y_up[DW-1]) begin
				x_q <= x_up + dx;
				y_q <= y_up - dy;
				z_q <= z_up + ATAN_STEP;
			end else begin
				x_q <= x_up - dx;
				y_q <= y_up + dy;
				z_q <= z_up - ATAN_STEP;
			end
		end
	end

	assign valid_dn = valid_q;
	assign x_dn     = x_q;
	assign y_dn     = y_q;
	assign z_dn     = z_q;
	assign zero_dn  = zero_q;

endmodule

[rtl/core/vang_out.sv]
// Output stage: clamp to 0..pi, round to the output format, hold the result.
module vang_out #(
	parameter int ANGLE_FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  valid_up,
	output logic                                  ready_up,
	input  logic signed [vang_pkg::Z_WIDTH-1:0]   z_up,
	input  logic                                  zero_up,
	output logic                                  valid_dn,
	input  logic                                  ready_dn,
	output logic [vang_pkg::ANGLE_WIDTH-1:0]      angle,
	output logic                                  zero_vector
);
	import vang_pkg::*;

	localparam int DROP = 32 - ANGLE_FRAC_BITS;
	localparam logic [Z_WIDTH:0] HALF = (Z_WIDTH + 1)'(1) << (DROP - 1);
	localparam logic [Z_WIDTH:0] PI_ROUND =
		(({1'b0, PI_Q32}) + HALF) >> DROP;

	logic                        valid_q;
	logic [ANGLE_WIDTH-1:0]      angle_q;
	logic                        zero_q;
	logic signed [Z_WIDTH-1:0]   z_clamp;
	logic [Z_WIDTH:0]            z_round;

	always_comb begin
		if (z_up[Z_WIDTH-1]) begin
			z_clamp = '0;
		end else if (z_up > PI_Q32) begin
			z_clamp = PI_Q32;
		end else begin
			z_clamp = z_up;
		end
	end

	assign z_round  = ({1'b0, z_clamp} + HALF) >> DROP;
	assign ready_up = !valid_q || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_up && ready_up) begin
			zero_q  <= zero_up;
			angle_q <= zero_up ? '0 : z_round[ANGLE_WIDTH-1:0];
		end
	end

	assign valid_dn    = valid_q;
	assign angle       = angle_q;
	assign zero_vector = zero_q;

`ifndef NO_ASSERTIONS
	a_zero_gives_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && zero_q |-> angle_q == '0)
		else $error("zero vector result with non-zero angle");

	a_angle_within_pi: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (ANGLE_FRAC_BITS <= 14) |-> (Z_WIDTH + 1)'(angle_q) <= PI_ROUND)
		else $error("angle beyond pi");

	a_transfer_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_up && ready_up |=> valid_q)
		else $error("accepted item lost at output stage");
`endif

endmodule

[rtl/core/vector_angle_2d.sv]
// Top level: unsigned angle between two 2-D vectors by pipelined CORDIC.
//
//   channel  dir  payload                                       handshake
//   pair     in   first_x, first_y, second_x, second_y (signed) valid/ready
//   result   out  angle (Q2.14, 0..pi), zero_vector             valid/ready
//
// One pair accepted per cycle unless the result side stalls. There are three
// front-end stages for products, sums and pre-rotation, one cell per CORDIC
// iteration and one output stage. Each stage holds its own valid and stalls only
// when full and the next stage is stalled. Reset clears the valid flags only.
module vector_angle_2d #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 14,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	vang_pair_if.sink    pair,
	vang_result_if.source result
);
	import vang_pkg::*;

	localparam int PW  = 2 * COORD_WIDTH;
	localparam int PRE = (PW > 60) ? PW - 60 : 0;
	localparam int DW  = PW - PRE + 3;

	logic                      valid_c [0:CORDIC_STEPS];
	logic                      ready_c [0:CORDIC_STEPS];
	logic signed [DW-1:0]      x_c     [0:CORDIC_STEPS];
	logic signed [DW-1:0]      y_c     [0:CORDIC_STEPS];
	logic signed [Z_WIDTH-1:0] z_c     [0:CORDIC_STEPS];
	logic                      zero_c  [0:CORDIC_STEPS];

	vang_prep #(
		.COORD_WIDTH (COORD_WIDTH),
		.DW          (DW)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_up (pair.valid),
		.ready_up (pair.ready),
		.x1       (COORD_WIDTH'(pair.first_x)),
		.y1       (COORD_WIDTH'(pair.first_y)),
		.x2       (COORD_WIDTH'(pair.second_x)),
		.y2       (COORD_WIDTH'(pair.second_y)),
		.valid_dn (valid_c[0]),
		.ready_dn (ready_c[0]),
		.x_dn     (x_c[0]),
		.y_dn     (y_c[0]),
		.z_dn     (z_c[0]),
		.zero_dn  (zero_c[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		vang_cell #(
			.DW   (DW),
			.STEP (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_up (valid_c[i]),
			.ready_up (ready_c[i]),
			.x_up     (x_c[i]),
			.y_up     (y_c[i]),
			.z_up     (z_c[i]),
			.zero_up  (zero_c[i]),
			.valid_dn (valid_c[i+1]),
			.ready_dn (ready_c[i+1]),
			.x_dn     (x_c[i+1]),
			.y_dn     (y_c[i+1]),
			.z_dn     (z_c[i+1]),
			.zero_dn  (zero_c[i+1])
		);
	end

	vang_out #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_up    (valid_c[CORDIC_STEPS]),
		.ready_up    (ready_c[CORDIC_STEPS]),
		.z_up        (z_c[CORDIC_STEPS]),
		.zero_up     (zero_c[CORDIC_STEPS]),
		.valid_dn    (result.valid),
		.ready_dn    (result.ready),
		.angle       (result.angle),
		.zero_vector (result.zero_vector)
	);

endmodule
